[rtl/core/ceu_pkg.sv]
package ceu_pkg;

    localparam logic [7:0] BACKSLASH   = 8'h5C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [1:0] OCT_MORE    = 2'd2;   // digits allowed after the first
    localparam int         QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_OCT   = 2'd2
    } phase_t;

    // One decoded transaction group: one or two result bytes.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
    } cmd_t;

    function automatic logic [7:0] map_simple(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h61:   r = 8'h07;  // a
            8'h62:   r = 8'h08;  // b
            8'h66:   r = 8'h0C;  // f
            8'h6E:   r = 8'h0A;  // n
            8'h72:   r = 8'h0D;  // r
            8'h74:   r = 8'h09;  // t
            8'h76:   r = 8'h0B;  // v
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/c_escape_unescaper_unit.sv]
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_stall  | in_byte[7:0], in_last
// output   | out       | out_valid / out_stall| out_byte[7:0], run_end, text_end
//
// One input transaction per cycle while in_stall is low; a result is registered in the
// queue when its input is accepted and leaves from the queue head.
// A step that yields two results (octal value plus the byte that ended the run)
// keeps its queue entry at the head until both have left; with input arriving every
// cycle the two-entry queue can then fill and stall the input.
// in_stall rises only when the queue is full; the output side stalls freely.
// rst_n is asynchronous, active low; escape state and queue clear at once.
module c_escape_unescaper_unit
    import ceu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       text_end
);

    logic take;
    logic push;
    cmd_t cmd;
    cmd_t head;
    logic head_valid;
    logic q_full;
    logic pop;
    logic sel;

    // Front accepts whenever the queue has room, even while a result waits.
    assign in_stall = q_full;
    assign take     = in_valid && !in_stall;

    // Front: escape state machine, classifies each byte into 0, 1 or 2 results.
    ceu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push),
        .cmd     (cmd)
    );

    // Decouples the front from output backpressure.
    ceu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (q_full)
    );

    // Back: walks the results of the head entry, one per transaction.
    ceu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .sel        (sel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .text_end   (text_end)
    );

    // Second-result pointer only ever sits on a live two-result entry.
    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        sel |-> (head_valid && head.two))
        else $error("second result selected without a two-result entry");

    // Never write into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue overflow");

    // A two-result entry that moves its first result must show the second next.
    a_two_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !run_end) |=> (out_valid && sel))
        else $error("second result lost");

    // End of text always closes a run.
    a_text_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && text_end) |-> run_end)
        else $error("text_end without run_end");

endmodule

[rtl/core/ceu_front.sv]
module ceu_front
    import ceu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output cmd_t       cmd
);

    phase_t     phase_reg, phase_next;
    logic [7:0] acc_reg, acc_next;
    logic [1:0] left_reg, left_next;

    logic       is_oct;
    logic       is_bs;
    logic [2:0] digit;
    logic [7:0] acc_shift;
    logic       oct_done;

    assign is_oct    = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_SEVEN);
    assign is_bs     = (in_byte == BACKSLASH);
    assign digit     = in_byte[2:0];
    assign acc_shift = {acc_reg[4:0], digit};     // acc * 8 + digit, mod 256
    assign oct_done  = (left_reg <= 2'd1) || in_last;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        unique case (phase_reg)
            PH_ESC:
            begin
                if (is_oct)
                begin
                    acc_next   = {5'd0, digit};
                    left_next  = OCT_MORE;
                    phase_next = PH_OCT;
                end
                else
                begin
                    phase_next = PH_PLAIN;
                end
            end
            PH_OCT:
            begin
                if (is_oct && !oct_done)
                begin
                    acc_next  = acc_shift;
                    left_next = left_reg - 2'd1;
                end
                else
                begin
                    acc_next   = 8'd0;
                    left_next  = 2'd0;
                    phase_next = (!is_oct && is_bs && !in_last) ? PH_ESC : PH_PLAIN;
                end
            end
            default:
            begin
                phase_next = (is_bs && !in_last) ? PH_ESC : PH_PLAIN;
            end
        endcase
        if (in_last)
        begin
            phase_next = PH_PLAIN;
            acc_next   = 8'd0;
            left_next  = 2'd0;
        end
    end

    // outputs
    always_comb
    begin
        logic emit;
        emit      = 1'b0;
        cmd.two   = 1'b0;
        cmd.byte0 = in_byte;
        cmd.byte1 = in_byte;
        cmd.last  = in_last;
        unique case (phase_reg)
            PH_ESC:
            begin
                if (is_oct)
                begin
                    emit      = in_last;
                    cmd.byte0 = {5'd0, digit};
                end
                else
                begin
                    emit      = 1'b1;
                    cmd.byte0 = map_simple(in_byte);
                end
            end
            PH_OCT:
            begin
                if (is_oct)
                begin
                    emit      = oct_done;
                    cmd.byte0 = acc_shift;
                end
                else
                begin
                    // value first, then the byte that ended the run
                    emit      = 1'b1;
                    cmd.byte0 = acc_reg;
                    cmd.two   = !(is_bs && !in_last);
                end
            end
            default:
            begin
                emit = !(is_bs && !in_last);
            end
        endcase
        push = take && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            acc_reg   <= 8'd0;
            left_reg  <= 2'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
        end
    end

endmodule

[rtl/core/ceu_queue.sv]
module ceu_queue
    import ceu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_t       wr_cmd,
    input  logic       pop,
    output cmd_t       head,
    output logic       not_empty,
    output logic       full
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t            mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;

    assign head      = mem_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (PW+1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/core/ceu_back.sv]
module ceu_back
    import ceu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       sel,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       text_end
);

    logic sel_reg, sel_next;
    logic fire;

    assign fire      = head_valid && !out_stall;
    assign out_valid = head_valid;
    assign out_byte  = sel_reg ? head.byte1 : head.byte0;
    assign run_end   = !head.two || sel_reg;
    assign text_end  = run_end && head.last;
    assign pop       = fire && run_end;
    assign sel       = sel_reg;

    always_comb
    begin
        sel_next = sel_reg;
        if (fire)
            sel_next = !run_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

endmodule

[sim/c_escape_unescaper_unit_tb.sv]
`timescale 1ns / 1ps

module c_escape_unescaper_unit_tb;
    import ceu_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int TARGET_ITEMS   = 1600;
    // Long receiver hold-off: more than enough for the block to fill its queue.
    localparam int HOLD_CYCLES    = 80;
    // Cycles with no transaction on either side before the run is declared hung.
    // The slowest legal stretch is a hold-off plus a long gap, well under this.
    localparam int WATCHDOG_LIMIT = 1500;
    // Results are registered in the queue on acceptance, and the queue is two deep.
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    // One decoded byte as it should leave the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       text_end;
    } dec_byte_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;

    // Shadow of the decoder state, kept in step with accepted input transactions.
    phase_t     esc_phase = PH_PLAIN;
    logic [7:0] oct_value = 8'h00;
    logic [1:0] oct_left  = 2'd0;

    dec_byte_t  decoded_q[$];      // bytes the block still owes us, oldest first
    dec_byte_t  want;
    logic [7:0] text_q[$];         // one text under construction for the random part
    int         err_count   = 0;
    int         items_sent  = 0;
    int         quiet_cycles = 0;
    int         rx_wait;
    bit         tx_gaps_on  = 1'b1;
    bit         rx_stall_on = 1'b1;
    bit         hold_req    = 1'b0;

    c_escape_unescaper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_end   (run_end),
        .text_end  (text_end)
    );

    // 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // Letter after a backslash -> control code; anything else stands for itself.
    function automatic logic [7:0] control_code(input logic [7:0] c);
        case (c)
            "a":     return 8'h07;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            "v":     return 8'h0B;
            default: return c;
        endcase
    endfunction

    // Append one byte to the text under construction.
    function automatic void add_text(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    // Advance the shadow state by one accepted byte and queue what it yields.
    function automatic void decode_step(input logic [7:0] c, input logic last);
        logic [7:0] outs [0:1];
        int         n;
        logic       is_digit;
        logic       pass;
        dec_byte_t  entry;
        n        = 0;
        pass     = 1'b0;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
        case (esc_phase)
            PH_ESC:
            begin
                if (is_digit)
                begin
                    oct_value = c - CHAR_ZERO;
                    oct_left  = OCT_MORE;
                    esc_phase = PH_OCT;
                    // text ends right after the first digit
                    if (last)
                    begin
                        outs[n] = oct_value;
                        n = n + 1;
                    end
                end
                else
                begin
                    // 8 and 9 land here too and come out as themselves
                    esc_phase = PH_PLAIN;
                    outs[n] = control_code(c);
                    n = n + 1;
                end
            end
            PH_OCT:
            begin
                if (is_digit)
                begin
                    // value kept modulo 256
                    oct_value = {oct_value[4:0], 3'b000} + (c - CHAR_ZERO);
                    if (oct_left <= 2'd1 || last)
                    begin
                        outs[n] = oct_value;
                        n = n + 1;
                        esc_phase = PH_PLAIN;
                        oct_value = 8'h00;
                        oct_left  = 2'd0;
                    end
                    else
                    begin
                        oct_left = oct_left - 2'd1;
                    end
                end
                else
                begin
                    // non-digit closes the run: value first, then the byte itself
                    outs[n] = oct_value;
                    n = n + 1;
                    esc_phase = PH_PLAIN;
                    oct_value = 8'h00;
                    oct_left  = 2'd0;
                    pass = 1'b1;
                end
            end
            default:
            begin
                esc_phase = PH_PLAIN;
                pass = 1'b1;
            end
        endcase
        if (pass)
        begin
            // a backslash opens an escape unless the text ends on it
            if (c == BACKSLASH && !last)
            begin
                esc_phase = PH_ESC;
            end
            else
            begin
                outs[n] = c;
                n = n + 1;
            end
        end
        if (last)
        begin
            esc_phase = PH_PLAIN;
            oct_value = 8'h00;
            oct_left  = 2'd0;
        end
        for (int i = 0; i < n; i++)
        begin
            entry.data     = outs[i];
            entry.run_end  = (i == n - 1);
            entry.text_end = (i == n - 1) && last;
            decoded_q.insert(decoded_q.size(), entry);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Offer one input transaction and wait until the block takes it. Valid stays
    // high afterwards; the next call (or drop_valid) decides at the next falling
    // edge whether it goes low or carries a new payload.
    task automatic send_item(input logic [7:0] b, input logic l);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_step(b, l);
        items_sent = items_sent + 1;
    endtask

    task automatic send_string(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], last_at_end && (i == s.len() - 1));
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        rx_wait   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rx_wait  = HOLD_CYCLES;
            end
            else if (rx_wait == 0 && rx_stall_on)
            begin
                rx_wait = pick_gap();
            end
            if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                rx_wait = rx_wait - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        err_count = err_count + 1;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Every accepted output transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                report_error($sformatf("result with nothing pending, out_byte=%02h",
                                       out_byte));
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.data)
                    report_error($sformatf("out_byte expected %02h got %02h",
                                           want.data, out_byte));
                if (run_end !== want.run_end)
                    report_error($sformatf("run_end expected %0b got %0b (byte %02h)",
                                           want.run_end, run_end, want.data));
                if (text_end !== want.text_end)
                    report_error($sformatf("text_end expected %0b got %0b (byte %02h)",
                                           want.text_end, text_end, want.data));
            end
        end
    end

    // Hang detector: any transaction on either channel resets the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", decoded_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All seven letter escapes.
    task automatic test_simple_escapes();
        send_string("\\a\\b\\f\\n\\r\\t\\v", 1'b0);
    endtask

    // Octal runs and the edge cases around them.
    task automatic test_octal_escapes();
        send_string("\\777", 1'b0);          // ends by count, wraps to 0xFF
        send_string("\\2\\", 1'b0);          // backslash ends run and opens a new escape
        send_item(8'h00, 1'b0);              // unknown escape of 0x00
        send_string("\\18", 1'b0);           // 8 is not octal: value then '8'
        send_item(8'hFF, 1'b0);              // plain top byte
        send_string("\\5", 1'b1);            // text ends inside the run
        send_item(BACKSLASH, 1'b1);          // lone trailing backslash
    endtask

    // Receiver holds off while the sender pushes two-result transactions
    // back to back, so the output queue fills and in_stall has to rise.
    task automatic test_full_queue();
        tx_gaps_on = 1'b0;
        hold_req   = 1'b1;
        repeat (6)
            send_string("\\12x", 1'b0);
        tx_gaps_on = 1'b1;
    endtask

    // Random texts: mostly well-formed escapes with random content, some noise,
    // and texts that end in the middle of an escape.
    task automatic build_text();
        string      esc_chars;
        int         tokens;
        int         pick;
        logic [7:0] b;
        esc_chars = "abfnrtv\"?\\'";
        tokens    = $urandom_range(1, 30);
        text_q.delete();
        repeat (tokens)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == BACKSLASH)
                    b = "/";
                add_text(b);
            end
            else if (pick < 65)
            begin
                add_text(BACKSLASH);
                add_text(esc_chars[$urandom_range(0, esc_chars.len() - 1)]);
            end
            else if (pick < 85)
            begin
                add_text(BACKSLASH);
                repeat ($urandom_range(1, 3))
                    add_text(CHAR_ZERO + 8'($urandom_range(0, 7)));
            end
            else if (pick < 93)
            begin
                add_text(BACKSLASH);
                repeat ($urandom_range(1, 2))
                    add_text(CHAR_ZERO + 8'($urandom_range(0, 7)));
                add_text($urandom_range(0, 1) ? "8" : "9");
            end
            else
            begin
                // noise: anything, backslash included
                add_text(8'($urandom_range(0, 255)));
                add_text(8'($urandom_range(0, 255)));
            end
        end
        // dangling escape at the end of the text
        pick = $urandom_range(0, 9);
        if (pick <= 2)
        begin
            add_text(BACKSLASH);
            repeat (pick)
                add_text(CHAR_ZERO + 8'($urandom_range(0, 7)));
        end
    endtask

    task automatic test_random_text();
        while (items_sent < TARGET_ITEMS)
        begin
            build_text();
            // some texts run with no idling on one or both sides
            tx_gaps_on  = ($urandom_range(0, 4) != 0);
            rx_stall_on = ($urandom_range(0, 4) != 0);
            foreach (text_q[i])
                send_item(text_q[i], i == text_q.size() - 1);
        end
        rx_stall_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        in_last  = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_simple_escapes();
        test_octal_escapes();
        test_full_queue();
        test_random_text();
        drop_valid();

        // everything owed must arrive; the watchdog covers a hang here
        while (decoded_q.size() != 0)
            @(posedge clk);
        // catch any stray extra results
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
